/* sv/bounded_sequential_list_engine_core_macros.svh */
// assertion helpers for the list engine checker
`ifndef BOUNDED_SEQUENTIAL_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_SEQUENTIAL_LIST_ENGINE_CORE_MACROS_SVH

// implication in the same cycle
`define BSLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// implication into the next cycle
`define BSLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

/* sv/bsle_pkg.sv */
package bsle_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = AW + 1;

    typedef enum logic [3:0] {
        MODE_PUSH_BACK  = 4'd0,
        MODE_POP_BACK   = 4'd1,
        MODE_PUSH_FRONT = 4'd2,
        MODE_POP_FRONT  = 4'd3,
        MODE_INSERT     = 4'd4,
        MODE_ERASE      = 4'd5,
        MODE_FIND       = 4'd6,
        MODE_REMOVE     = 4'd7,
        MODE_OVERWRITE  = 4'd8,
        MODE_SORT       = 4'd9,
        MODE_BSEARCH    = 4'd10,
        MODE_DUMP       = 4'd11
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    localparam logic ADDR_CAP = 1'b0;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] value;
        logic [5:0]         position;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               found;
        logic [4:0]         index;
        logic signed [31:0] value_out;
        logic [5:0]         count;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_t;

endpackage

/* sv/bsle_cmp.sv */
module bsle_cmp (
    input  logic signed [bsle_pkg::DATA_WIDTH-1:0] a,
    input  logic signed [bsle_pkg::DATA_WIDTH-1:0] b,
    output bsle_pkg::cmp_t                          res
);

    // signed three-way compare shared by find, sort and search
    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
        res.gt = (a > b);
    end

endmodule

/* sv/bounded_sequential_list_engine_core.sv */
// bounded list of signed 32-bit words in a simple dual-port memory with registered read,
// driven by a small sequencer around one shared signed comparator. one request word
// runs at a time and req_stall is high until its response words are queued. push back,
// pop back, overwrite and any failed check go straight to the response; a shift
// for push front, insert, pop front, erase or remove moves one entry per read and write;
// find reads one entry per probe; binary search reads one entry per probe; dump reads
// one element per response word; sort is a bubble sort over n(n-1)/2 compares.
// capacity_limit lives at apb address 0; the user must write it only while the block
// is idle, as the block itself does not enforce it.
module bounded_sequential_list_engine_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bsle_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bsle_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int DW = bsle_pkg::DATA_WIDTH;
    localparam int AW = bsle_pkg::AW;
    localparam int CW = bsle_pkg::CW;

    // sequencer states
    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_SHR  = 16'h0002,  // insert shift: read entry below
        S_SHW  = 16'h0004,  // insert shift: write it one up
        S_ERR  = 16'h0008,  // erase shift: read entry above
        S_ERW  = 16'h0010,  // erase shift: write it one down
        S_FRD  = 16'h0020,
        S_FCK  = 16'h0040,
        S_SRA  = 16'h0080,
        S_SRB  = 16'h0100,
        S_SCK  = 16'h0200,
        S_SWB  = 16'h0400,
        S_BRD  = 16'h0800,
        S_BCK  = 16'h1000,
        S_DRD  = 16'h2000,
        S_DEM  = 16'h4000,
        S_DONE = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [5:0]           cap_reg, cap_next;
    logic [3:0]           mode_reg, mode_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        i_reg, i_next;      // walk index, also sort j and search mid
    logic [CW-1:0]        lim_reg, lim_next;  // sort inner bound
    logic signed [CW:0]   lo_reg, lo_next;
    logic signed [CW:0]   hi_reg, hi_next;
    logic signed [DW-1:0] a_reg, a_next;
    logic [2:0]           st_reg, st_next;
    logic                 fnd_reg, fnd_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic signed [DW-1:0] rdata_reg;
    bsle_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // memory port
    logic signed [DW-1:0] mem [bsle_pkg::DEPTH];
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic                 re;
    logic [AW-1:0]        raddr;

    logic                 req_take;
    logic                 rsp_free;
    logic [CW-1:0]        cap_eff;
    logic                 is_full;
    logic [CW-1:0]        ip1;
    logic [CW-1:0]        im1;
    logic signed [CW+1:0] lohi_sum;
    logic signed [DW-1:0] cmp_a;
    logic signed [DW-1:0] cmp_b;
    bsle_pkg::cmp_t       cmp_res;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == bsle_pkg::ADDR_CAP) ? {26'd0, cap_reg} : 32'd0;

    // capacity above depth acts as depth
    assign cap_eff  = (cap_reg > 6'(bsle_pkg::DEPTH)) ? CW'(bsle_pkg::DEPTH) : CW'(cap_reg);
    assign is_full  = (cnt_reg >= cap_eff);
    assign ip1      = i_reg + 1'b1;
    assign im1      = i_reg - 1'b1;
    assign lohi_sum = (CW+2)'(lo_reg) + (CW+2)'(hi_reg);

    // sort compares held word against fresh read; find and search compare read vs key
    assign cmp_a = (state_reg == S_SCK) ? a_reg : rdata_reg;
    assign cmp_b = (state_reg == S_SCK) ? rdata_reg : val_reg;

    bsle_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cap_next       = cap_reg;
        mode_next      = mode_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        lim_next       = lim_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        st_next        = st_reg;
        fnd_next       = fnd_reg;
        idx_next       = idx_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        we             = 1'b0;
        waddr          = '0;
        wdata          = val_reg;
        re             = 1'b0;
        raddr          = '0;

        if (psel && penable && pwrite && (paddr[2] == bsle_pkg::ADDR_CAP))
        begin
            cap_next = pwdata[5:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    mode_next  = req.mode;
                    val_next   = req.value;
                    pos_next   = req.position;
                    st_next    = bsle_pkg::ST_OK;
                    fnd_next   = 1'b0;
                    idx_next   = '0;
                    state_next = S_DONE;
                    case (req.mode)
                        bsle_pkg::MODE_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                st_next = bsle_pkg::ST_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = cnt_reg[AW-1:0];
                                wdata    = req.value;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        bsle_pkg::MODE_POP_BACK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = bsle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        bsle_pkg::MODE_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                st_next = bsle_pkg::ST_FULL;
                            end
                            else
                            begin
                                pos_next   = '0;
                                i_next     = cnt_reg;
                                state_next = S_SHR;
                            end
                        end
                        bsle_pkg::MODE_POP_FRONT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = bsle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = S_ERR;
                            end
                        end
                        bsle_pkg::MODE_INSERT:
                        begin
                            if (is_full)
                            begin
                                st_next = bsle_pkg::ST_FULL;
                            end
                            else if (req.position > cnt_reg)
                            begin
                                st_next = bsle_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                i_next     = cnt_reg;
                                state_next = S_SHR;
                            end
                        end
                        bsle_pkg::MODE_ERASE:
                        begin
                            if (req.position >= cnt_reg)
                            begin
                                st_next = bsle_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                i_next     = req.position;
                                state_next = S_ERR;
                            end
                        end
                        bsle_pkg::MODE_FIND,
                        bsle_pkg::MODE_REMOVE:
                        begin
                            i_next     = '0;
                            state_next = S_FRD;
                        end
                        bsle_pkg::MODE_OVERWRITE:
                        begin
                            if (req.position >= cnt_reg)
                            begin
                                st_next = bsle_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = req.position[AW-1:0];
                                wdata = req.value;
                            end
                        end
                        bsle_pkg::MODE_SORT:
                        begin
                            if (cnt_reg > CW'(1))
                            begin
                                lim_next   = cnt_reg - 1'b1;
                                i_next     = '0;
                                state_next = S_SRA;
                            end
                        end
                        bsle_pkg::MODE_BSEARCH:
                        begin
                            st_next    = bsle_pkg::ST_NOTFOUND;
                            lo_next    = '0;
                            hi_next    = (CW+1)'(cnt_reg) - 1'b1;
                            state_next = S_BRD;
                        end
                        bsle_pkg::MODE_DUMP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                i_next     = '0;
                                state_next = S_DRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SHR:
            begin
                if (i_reg > pos_reg)
                begin
                    re         = 1'b1;
                    raddr      = im1[AW-1:0];
                    state_next = S_SHW;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = pos_reg[AW-1:0];
                    wdata      = val_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end
            end

            S_SHW:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = rdata_reg;
                i_next     = im1;
                state_next = S_SHR;
            end

            S_ERR:
            begin
                if (ip1 < cnt_reg)
                begin
                    re         = 1'b1;
                    raddr      = ip1[AW-1:0];
                    state_next = S_ERW;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_ERW:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = rdata_reg;
                i_next     = ip1;
                state_next = S_ERR;
            end

            S_FRD:
            begin
                if (i_reg < cnt_reg)
                begin
                    re         = 1'b1;
                    raddr      = i_reg[AW-1:0];
                    state_next = S_FCK;
                end
                else
                begin
                    st_next    = bsle_pkg::ST_NOTFOUND;
                    state_next = S_DONE;
                end
            end

            S_FCK:
            begin
                if (cmp_res.eq)
                begin
                    fnd_next   = 1'b1;
                    idx_next   = i_reg[AW-1:0];
                    state_next = (mode_reg == bsle_pkg::MODE_REMOVE) ? S_ERR : S_DONE;
                end
                else
                begin
                    i_next     = ip1;
                    state_next = S_FRD;
                end
            end

            S_SRA:
            begin
                if (i_reg < lim_reg)
                begin
                    re         = 1'b1;
                    raddr      = i_reg[AW-1:0];
                    state_next = S_SRB;
                end
                else if (lim_reg <= CW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lim_next = lim_reg - 1'b1;
                    i_next   = '0;
                end
            end

            S_SRB:
            begin
                a_next     = rdata_reg;
                re         = 1'b1;
                raddr      = ip1[AW-1:0];
                state_next = S_SCK;
            end

            S_SCK:
            begin
                if (cmp_res.gt)
                begin
                    we         = 1'b1;
                    waddr      = i_reg[AW-1:0];
                    wdata      = rdata_reg;
                    state_next = S_SWB;
                end
                else
                begin
                    i_next     = ip1;
                    state_next = S_SRA;
                end
            end

            S_SWB:
            begin
                we         = 1'b1;
                waddr      = ip1[AW-1:0];
                wdata      = a_reg;
                i_next     = ip1;
                state_next = S_SRA;
            end

            S_BRD:
            begin
                if (lo_reg <= hi_reg)
                begin
                    // both bounds are non-negative here, so the floor midpoint is a shift
                    i_next     = lohi_sum[CW:1];
                    re         = 1'b1;
                    raddr      = lohi_sum[AW:1];
                    state_next = S_BCK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_BCK:
            begin
                if (cmp_res.lt)
                begin
                    lo_next    = (CW+1)'(i_reg) + 1'b1;
                    state_next = S_BRD;
                end
                else if (cmp_res.gt)
                begin
                    hi_next    = (CW+1)'(i_reg) - 1'b1;
                    state_next = S_BRD;
                end
                else
                begin
                    st_next    = bsle_pkg::ST_OK;
                    fnd_next   = 1'b1;
                    idx_next   = i_reg[AW-1:0];
                    state_next = S_DONE;
                end
            end

            S_DRD:
            begin
                re         = 1'b1;
                raddr      = i_reg[AW-1:0];
                state_next = S_DEM;
            end

            S_DEM:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = bsle_pkg::ST_OK;
                    rsp_next.found     = 1'b0;
                    rsp_next.index     = i_reg[AW-1:0];
                    rsp_next.value_out = rdata_reg;
                    rsp_next.count     = cnt_reg;
                    rsp_next.last      = (ip1 == cnt_reg);
                    i_next             = ip1;
                    state_next         = (ip1 == cnt_reg) ? S_IDLE : S_DRD;
                end
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = st_reg;
                    rsp_next.found     = fnd_reg;
                    rsp_next.index     = idx_reg;
                    rsp_next.value_out = '0;
                    rsp_next.count     = cnt_reg;
                    rsp_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= 6'd32;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        val_reg  <= val_next;
        pos_reg  <= pos_next;
        i_reg    <= i_next;
        lim_reg  <= lim_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        a_reg    <= a_next;
        st_reg   <= st_next;
        fnd_reg  <= fnd_next;
        idx_reg  <= idx_next;
        rsp_reg  <= rsp_next;
    end

    // entry storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

/* sv/bsle_checker.sv */
`include "bounded_sequential_list_engine_core_macros.svh"

module bsle_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  bsle_pkg::rsp_t  rsp
);

    // a held response word stays put
    `BSLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // one request at a time: busy right after a request word is taken
    `BSLE_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

    // only dump gives more than one word, and those are all ok
    `BSLE_ASSERT_NOW(a_nonlast_ok, rsp_valid && !rsp.last, rsp.status == bsle_pkg::ST_OK)

    // a full report never carries a match
    `BSLE_ASSERT_NOW(a_full_clean, rsp_valid && (rsp.status == bsle_pkg::ST_FULL),
        rsp.last && !rsp.found)

endmodule

bind bounded_sequential_list_engine_core bsle_checker u_bsle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* bench/tb_bounded_sequential_list_engine_core.sv */
`timescale 1ns / 100ps

module tb_bounded_sequential_list_engine_core;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    bsle_pkg::req_t       req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    bsle_pkg::rsp_t       rsp;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    bounded_sequential_list_engine_core uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the list, kept in step with every accepted word
    logic signed [31:0] shadow_list [bsle_pkg::DEPTH];
    int unsigned        shadow_count;
    int unsigned        shadow_cap;

    bsle_pkg::req_t pending_words [$];
    bsle_pkg::rsp_t expected_words [$];

    int  fail_count;
    int  word_count;
    int  rsp_count;
    int  send_idle_pct;
    int  recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run (a sort of 32 entries)
    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned cap_now();
        return (shadow_cap > bsle_pkg::DEPTH) ? bsle_pkg::DEPTH : shadow_cap;
    endfunction

    function automatic bsle_pkg::rsp_t make_rsp(logic [2:0] st, logic fnd, logic [4:0] idx,
                                                logic signed [31:0] v, logic lst);
        bsle_pkg::rsp_t r;
        r.status    = st;
        r.found     = fnd;
        r.index     = idx;
        r.value_out = v;
        r.count     = shadow_count[5:0];
        r.last      = lst;
        return r;
    endfunction

    function automatic void list_insert(int unsigned p, logic signed [31:0] v);
        for (int unsigned i = shadow_count; i > p; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[p] = v;
        shadow_count++;
    endfunction

    function automatic void list_erase(int unsigned p);
        shadow_count--;
        for (int unsigned i = p; i < shadow_count; i++)
            shadow_list[i] = shadow_list[i+1];
    endfunction

    // works out the response words one request word causes and updates the shadow
    function automatic void predict_list_op(bsle_pkg::req_t w);
        logic [2:0]         st;
        logic               fnd;
        logic [4:0]         idx;
        int                 lo;
        int                 hi;
        int                 mid;
        int                 hit;
        logic signed [31:0] t;
        st  = bsle_pkg::ST_OK;
        fnd = 1'b0;
        idx = '0;
        case (w.mode)
            bsle_pkg::MODE_PUSH_BACK, bsle_pkg::MODE_PUSH_FRONT:
                if (shadow_count >= cap_now())
                    st = bsle_pkg::ST_FULL;
                else
                    list_insert((w.mode == bsle_pkg::MODE_PUSH_BACK) ? shadow_count : 0,
                                w.value);
            bsle_pkg::MODE_POP_BACK:
                if (shadow_count == 0) st = bsle_pkg::ST_EMPTY;
                else shadow_count--;
            bsle_pkg::MODE_POP_FRONT:
                if (shadow_count == 0) st = bsle_pkg::ST_EMPTY;
                else list_erase(0);
            bsle_pkg::MODE_INSERT:
                if (shadow_count >= cap_now()) st = bsle_pkg::ST_FULL;
                else if (w.position > shadow_count) st = bsle_pkg::ST_BADPOS;
                else list_insert(w.position, w.value);
            bsle_pkg::MODE_ERASE:
                if (w.position >= shadow_count) st = bsle_pkg::ST_BADPOS;
                else list_erase(w.position);
            bsle_pkg::MODE_FIND, bsle_pkg::MODE_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < int'(shadow_count); i++)
                    if (hit < 0 && shadow_list[i] == w.value)
                        hit = i;
                if (hit < 0)
                    st = bsle_pkg::ST_NOTFOUND;
                else
                begin
                    fnd = 1'b1;
                    idx = hit[4:0];
                    if (w.mode == bsle_pkg::MODE_REMOVE)
                        list_erase(hit);
                end
            end
            bsle_pkg::MODE_OVERWRITE:
                if (w.position >= shadow_count) st = bsle_pkg::ST_BADPOS;
                else shadow_list[w.position] = w.value;
            bsle_pkg::MODE_SORT:
                for (int i = 0; i + 1 < int'(shadow_count); i++)
                    for (int j = 0; j + 1 < int'(shadow_count) - i; j++)
                        if (shadow_list[j] > shadow_list[j+1])
                        begin
                            t = shadow_list[j];
                            shadow_list[j] = shadow_list[j+1];
                            shadow_list[j+1] = t;
                        end
            bsle_pkg::MODE_BSEARCH:
            begin
                lo = 0;
                hi = int'(shadow_count) - 1;
                st = bsle_pkg::ST_NOTFOUND;
                while (lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (shadow_list[mid] < w.value)
                        lo = mid + 1;
                    else if (shadow_list[mid] > w.value)
                        hi = mid - 1;
                    else
                    begin
                        st  = bsle_pkg::ST_OK;
                        fnd = 1'b1;
                        idx = mid[4:0];
                        lo  = hi + 1;
                    end
                end
            end
            bsle_pkg::MODE_DUMP:
            begin
                if (shadow_count == 0)
                    expected_words.push_back(make_rsp(bsle_pkg::ST_OK, 1'b0, '0, '0, 1'b1));
                for (int unsigned i = 0; i < shadow_count; i++)
                    expected_words.push_back(make_rsp(bsle_pkg::ST_OK, 1'b0, i[4:0],
                                                      shadow_list[i],
                                                      i + 1 == shadow_count));
                return;
            end
            default: ;
        endcase
        expected_words.push_back(make_rsp(st, fnd, idx, '0, 1'b1));
    endfunction

    // driver: one request word at a time, changes on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (req_valid && req_stall)
            ;
        else
        begin
            if (req_valid)
                void'(pending_words.pop_front());
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_valid <= 1'b1;
                req       <= pending_words[0];
            end
            else
                req_valid <= 1'b0;
        end
        rsp_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // shadow update at acceptance, so prediction follows the order the block sees
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            predict_list_op(req);
            word_count++;
        end
    end

    // monitor: compare each response word with the oldest expectation
    always @(posedge clk)
    begin
        bsle_pkg::rsp_t exp_w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_count++;
            if (expected_words.size() == 0)
            begin
                $display("%0t unexpected response word %p", $time, rsp);
                fail_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (rsp !== exp_w)
                begin
                    $display("%0t mismatch: expected %p actual %p", $time, exp_w, rsp);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_capacity(int unsigned cap);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {2'b00, bsle_pkg::ADDR_CAP};
        pwdata  <= cap;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_cap = cap & 63;
    endtask

    task automatic queue_word(bsle_pkg::mode_t m, logic signed [31:0] v, logic [5:0] p);
        bsle_pkg::req_t w;
        w.mode     = m;
        w.value    = v;
        w.position = p;
        pending_words.push_back(w);
    endtask

    // random word: mostly fills and list operations on small values so searches hit
    task automatic queue_random_word();
        logic signed [31:0] v;
        int unsigned sel;
        bsle_pkg::mode_t m;
        v = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(16)) - 8;
        sel = $urandom_range(99);
        if (sel < 30)
            m = ($urandom_range(1) == 0) ? bsle_pkg::MODE_PUSH_BACK : bsle_pkg::MODE_PUSH_FRONT;
        else if (sel < 37)
            m = bsle_pkg::MODE_DUMP;
        else
            m = bsle_pkg::mode_t'($urandom_range(11));
        queue_word(m, v, 6'($urandom_range(63) < 48 ? $urandom_range(shadow_count + 1)
                                                    : $urandom_range(63)));
    endtask

    initial
    begin
        int caps [5] = '{32, 1, 5, 0, 40};
        int idle_sets [4][2] = '{'{0, 0}, '{68, 0}, '{0, 68}, '{21, 21}};
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        word_count = 0;
        rsp_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_count = 0;
        shadow_cap = 32;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty cases, extremes, every operation
        queue_word(bsle_pkg::MODE_DUMP, 0, 0);
        queue_word(bsle_pkg::MODE_POP_BACK, 0, 0);
        queue_word(bsle_pkg::MODE_POP_FRONT, 0, 0);
        queue_word(bsle_pkg::MODE_ERASE, 0, 0);
        queue_word(bsle_pkg::MODE_OVERWRITE, 0, 0);
        queue_word(bsle_pkg::MODE_INSERT, 5, 1);
        queue_word(bsle_pkg::MODE_BSEARCH, 3, 0);
        queue_word(bsle_pkg::MODE_PUSH_BACK, 32'sh7fffffff, 0);
        queue_word(bsle_pkg::MODE_PUSH_FRONT, 32'sh80000000, 0);
        queue_word(bsle_pkg::MODE_INSERT, -1, 1);
        queue_word(bsle_pkg::MODE_INSERT, 7, 3);
        queue_word(bsle_pkg::MODE_INSERT, 9, 63);
        queue_word(bsle_pkg::MODE_FIND, -1, 0);
        queue_word(bsle_pkg::MODE_FIND, 123, 0);
        queue_word(bsle_pkg::MODE_BSEARCH, 7, 0);
        queue_word(bsle_pkg::MODE_SORT, 0, 0);
        queue_word(bsle_pkg::MODE_BSEARCH, 7, 0);
        queue_word(bsle_pkg::MODE_BSEARCH, 8, 0);
        queue_word(bsle_pkg::MODE_OVERWRITE, 32'sh5a5aa5a5, 2);
        queue_word(bsle_pkg::MODE_REMOVE, 32'sh7fffffff, 0);
        queue_word(bsle_pkg::MODE_ERASE, 0, 0);
        queue_word(bsle_pkg::mode_t'(4'd13), 0, 0);
        queue_word(bsle_pkg::MODE_DUMP, 0, 0);
        wait_drained();

        // pause with everything drained, then walk capacity and idle settings
        for (int ph = 0; ph < 5; ph++)
        begin
            write_capacity(caps[ph]);
            send_idle_pct  = idle_sets[ph % 4][0];
            recv_stall_pct = idle_sets[ph % 4][1];
            for (int k = 0; k < 39; k++)
            begin
                while (pending_words.size() > 2)
                    @(posedge clk);
                queue_random_word();
            end
            queue_word(bsle_pkg::MODE_DUMP, 0, 0);
            wait_drained();
        end

        $display("covered %0d request words, %0d response words, capacities 0..40",
                 word_count, rsp_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/bsle_pkg.sv
sv/bsle_cmp.sv
sv/bounded_sequential_list_engine_core.sv
sv/bsle_checker.sv
bench/tb_bounded_sequential_list_engine_core.sv
